/* hdl/tomis_pkg.sv */
package tomis_pkg;

    // Model defaults for the top-level parameters.
    localparam int ADD_STATIONS_DEF = 3;
    localparam int MUL_STATIONS_DEF = 2;
    localparam int NUM_REGS_DEF     = 5;
    localparam int DATA_WIDTH_DEF   = 32;

    // Latency register reset values.
    localparam logic [5:0] ADD_LAT_RST = 6'd2;
    localparam logic [5:0] MUL_LAT_RST = 6'd10;
    localparam logic [5:0] DIV_LAT_RST = 6'd40;

    // Configuration register indexes.
    localparam logic [1:0] REG_ADD_LAT = 2'd0;
    localparam logic [1:0] REG_MUL_LAT = 2'd1;
    localparam logic [1:0] REG_DIV_LAT = 2'd2;

    // Instruction codes.
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_ADDI = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_DIV  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the input word
        logic md_start;  // start the multiply/divide unit
        logic wb;        // apply both writebacks
        logic issue;     // dispatch and issue
        logic out_load;  // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_finish;  // mul/div unit writes back on this tick
        logic md_done;     // multiply/divide unit finished
        logic out_full;    // output register holds an untaken word
    } stat_t;

endpackage

/* hdl/tomis_muldiv.sv */
module tomis_muldiv #(
    parameter int DW = tomis_pkg::DATA_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          is_div,
    input  logic [DW-1:0] op_a,
    input  logic [DW-1:0] op_b,
    output logic          done,
    output logic [DW-1:0] result,
    output logic          dz
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          div_reg, div_next;
    logic          neg_reg, neg_next;
    logic          dz_reg, dz_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic [DW-1:0] mag_a, mag_b;

    always_comb begin
        mag_a = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
        mag_b = op_b[DW-1] ? (~op_b + 1'b1) : op_b;
        rem_sh  = {acc_reg, b_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, a_reg};
    end

    // One multiplier bit or one quotient bit per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            div_next  = is_div;
            acc_next  = '0;
            if (is_div) begin
                a_next   = mag_b;
                b_next   = mag_a;
                neg_next = op_a[DW-1] ^ op_b[DW-1];
                dz_next  = (op_b == '0);
            end else begin
                a_next   = op_a;
                b_next   = op_b;
                neg_next = 1'b0;
                dz_next  = 1'b0;
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!rem_sub[DW]) begin
                    acc_next = rem_sub[DW-1:0];
                    b_next   = {b_reg[DW-2:0], 1'b1};
                end else begin
                    acc_next = rem_sh[DW-1:0];
                    b_next   = {b_reg[DW-2:0], 1'b0};
                end
            end else begin
                acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
                a_next   = {a_reg[DW-2:0], 1'b0};
                b_next   = {1'b0, b_reg[DW-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        div_reg <= div_next;
        neg_reg <= neg_next;
        dz_reg  <= dz_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    // Product passes through; quotient sign fix-up; a zero divisor forces zero.
    always_comb begin
        if (!div_reg)    result = acc_reg;
        else if (dz_reg) result = '0;
        else if (neg_reg) result = ~b_reg + 1'b1;
        else             result = b_reg;
    end

    assign done = done_reg;
    assign dz   = div_reg & dz_reg;

endmodule

/* hdl/tomis_ctrl.sv */
module tomis_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tomis_pkg::stat_t stat,
    output tomis_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MDWAIT,
        ST_APPLY,
        ST_ISSUE,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    // Sequence of one tick: latch the word, writeback results, then dispatch and issue, then load the output.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.mul_finish) begin
                    cmd.md_start = 1'b1;
                    state_next   = ST_MDWAIT;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_MDWAIT: begin
                if (stat.md_done) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.wb     = 1'b1;
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                cmd.issue  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!stat.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* hdl/tomis_dp.sv */
module tomis_dp #(
    parameter int ADD_STATIONS = tomis_pkg::ADD_STATIONS_DEF,
    parameter int MUL_STATIONS = tomis_pkg::MUL_STATIONS_DEF,
    parameter int NUM_REGS     = tomis_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH   = tomis_pkg::DATA_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tomis_pkg::cmd_t  cmd,
    output tomis_pkg::stat_t stat,
    input  logic [31:0]      in_word,
    input  logic [5:0]       add_lat,
    input  logic [5:0]       mul_lat,
    input  logic [5:0]       div_lat,
    output logic [79:0]      out_word,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int NS  = ADD_STATIONS + MUL_STATIONS;
    localparam int TW  = $clog2(NS + 1);
    localparam int SW  = (NS > 1) ? $clog2(NS) : 1;
    localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DW  = DATA_WIDTH;

    // Architectural state.
    logic [DW-1:0] rval_reg [NUM_REGS];
    logic [TW-1:0] rtag_reg [NUM_REGS];
    logic          sbusy_reg [NS];
    logic          skind_reg [NS];
    logic [TW-1:0] stag_reg  [NS][2];
    logic [DW-1:0] sval_reg  [NS][2];
    logic [2:0]    sdest_reg [NS];
    logic          ubusy_reg [2];
    logic [SW-1:0] usta_reg  [2];
    logic [5:0]    ucnt_reg  [2];

    logic [31:0]   in_reg;
    logic [73:0]   res_reg;
    logic [79:0]   out_reg;
    logic          ovld_reg;

    // Input word fields.
    logic [2:0]  f_op, f_dst, f_s1, f_s2;
    logic [15:0] f_imm;
    assign f_op  = in_reg[2:0];
    assign f_dst = in_reg[5:3];
    assign f_s1  = in_reg[8:6];
    assign f_s2  = in_reg[11:9];
    assign f_imm = in_reg[27:12];

    // Writeback results.
    logic          fin_a, fin_m;
    logic [SW-1:0] sa, sm;
    logic [TW-1:0] ta, tm;
    logic [DW-1:0] ra, rm;
    logic [DW-1:0] md_res;
    logic          md_done, md_dz;

    assign fin_a = ubusy_reg[0] && (ucnt_reg[0] <= 6'd1);
    assign fin_m = ubusy_reg[1] && (ucnt_reg[1] <= 6'd1);
    assign sa = usta_reg[0];
    assign sm = usta_reg[1];
    assign ta = TW'(sa) + TW'(1);
    assign tm = TW'(sm) + TW'(1);
    assign ra = skind_reg[sa] ? (sval_reg[sa][0] - sval_reg[sa][1])
                              : (sval_reg[sa][0] + sval_reg[sa][1]);
    assign rm = md_res;

    tomis_muldiv #(.DW(DW)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .is_div  (skind_reg[sm]),
        .op_a    (sval_reg[sm][0]),
        .op_b    (sval_reg[sm][1]),
        .done    (md_done),
        .result  (md_res),
        .dz      (md_dz)
    );

    // Dispatch selection: highest ready station of each class.
    logic          dfa, dfm;
    logic [SW-1:0] dsa, dsm;
    always_comb begin
        dfa = 1'b0;
        dsa = '0;
        dfm = 1'b0;
        dsm = '0;
        for (int i = 0; i < ADD_STATIONS; i++) begin
            if (sbusy_reg[i] && stag_reg[i][0] == '0 && stag_reg[i][1] == '0) begin
                dfa = 1'b1;
                dsa = SW'(i);
            end
        end
        for (int i = ADD_STATIONS; i < NS; i++) begin
            if (sbusy_reg[i] && stag_reg[i][0] == '0 && stag_reg[i][1] == '0) begin
                dfm = 1'b1;
                dsm = SW'(i);
            end
        end
    end

    // Issue decode: lowest free station of the class.
    logic          is_imm, op_ok, idx_ok, is_mulc, ifound, do_issue;
    logic [SW-1:0] isel;
    logic [RIW-1:0] i_d, i_a, i_b;
    logic [DW+15:0] imm_ext;
    always_comb begin
        is_imm  = (f_op == tomis_pkg::OP_ADDI);
        op_ok   = (f_op != tomis_pkg::OP_NONE) && (f_op <= tomis_pkg::OP_DIV);
        idx_ok  = (32'(f_dst) < NUM_REGS) && (32'(f_s1) < NUM_REGS)
                  && (is_imm || (32'(f_s2) < NUM_REGS));
        is_mulc = (f_op == tomis_pkg::OP_MUL) || (f_op == tomis_pkg::OP_DIV);
        ifound  = 1'b0;
        isel    = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!sbusy_reg[i] && ((i >= ADD_STATIONS) == is_mulc)) begin
                ifound = 1'b1;
                isel   = SW'(i);
            end
        end
        do_issue = op_ok && idx_ok && ifound;
        i_d = RIW'(f_dst);
        i_a = RIW'(f_s1);
        i_b = RIW'(f_s2);
        imm_ext = {{DW{f_imm[15]}}, f_imm};
    end

    // State updates for writeback, dispatch and issue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                rval_reg[r] <= DW'(r * 2);
                rtag_reg[r] <= '0;
            end
            for (int i = 0; i < NS; i++) begin
                sbusy_reg[i] <= 1'b0;
                skind_reg[i] <= 1'b0;
                stag_reg[i][0] <= '0;
                stag_reg[i][1] <= '0;
                sval_reg[i][0] <= '0;
                sval_reg[i][1] <= '0;
                sdest_reg[i]   <= '0;
            end
            for (int u = 0; u < 2; u++) begin
                ubusy_reg[u] <= 1'b0;
                usta_reg[u]  <= '0;
                ucnt_reg[u]  <= '0;
            end
        end else if (cmd.wb) begin
            // Broadcast both results to waiting operands.
            for (int i = 0; i < NS; i++) begin
                for (int k = 0; k < 2; k++) begin
                    if (sbusy_reg[i] && fin_a && stag_reg[i][k] == ta) begin
                        stag_reg[i][k] <= '0;
                        sval_reg[i][k] <= ra;
                    end
                    if (sbusy_reg[i] && fin_m && stag_reg[i][k] == tm) begin
                        stag_reg[i][k] <= '0;
                        sval_reg[i][k] <= rm;
                    end
                end
            end
            // Register file takes a result only if still renamed to it.
            for (int r = 0; r < NUM_REGS; r++) begin
                if (fin_a && 32'(sdest_reg[sa]) == r && rtag_reg[r] == ta) begin
                    rval_reg[r] <= ra;
                    rtag_reg[r] <= '0;
                end
                if (fin_m && 32'(sdest_reg[sm]) == r && rtag_reg[r] == tm) begin
                    rval_reg[r] <= rm;
                    rtag_reg[r] <= '0;
                end
            end
            // Free finished stations and count down the units.
            for (int u = 0; u < 2; u++) begin
                if (ubusy_reg[u]) begin
                    if (ucnt_reg[u] > 6'd1) begin
                        ucnt_reg[u] <= ucnt_reg[u] - 6'd1;
                    end else begin
                        ubusy_reg[u]   <= 1'b0;
                        usta_reg[u]    <= '0;
                        ucnt_reg[u]    <= '0;
                        sbusy_reg[usta_reg[u]]    <= 1'b0;
                        skind_reg[usta_reg[u]]    <= 1'b0;
                        stag_reg[usta_reg[u]][0]  <= '0;
                        stag_reg[usta_reg[u]][1]  <= '0;
                        sval_reg[usta_reg[u]][0]  <= '0;
                        sval_reg[usta_reg[u]][1]  <= '0;
                        sdest_reg[usta_reg[u]]    <= '0;
                    end
                end
            end
        end else if (cmd.issue) begin
            // Dispatch ready stations to idle units.
            if (!ubusy_reg[0] && dfa) begin
                ubusy_reg[0] <= 1'b1;
                usta_reg[0]  <= dsa;
                ucnt_reg[0]  <= (add_lat == 6'd0) ? 6'd1 : add_lat;
            end
            if (!ubusy_reg[1] && dfm) begin
                ubusy_reg[1] <= 1'b1;
                usta_reg[1]  <= dsm;
                if (skind_reg[dsm]) ucnt_reg[1] <= (div_lat == 6'd0) ? 6'd1 : div_lat;
                else                ucnt_reg[1] <= (mul_lat == 6'd0) ? 6'd1 : mul_lat;
            end
            // Issue into the chosen station and rename the destination.
            if (do_issue) begin
                sbusy_reg[isel] <= 1'b1;
                skind_reg[isel] <= (f_op == tomis_pkg::OP_SUB) || (f_op == tomis_pkg::OP_DIV);
                if (rtag_reg[i_a] != '0) begin
                    stag_reg[isel][0] <= rtag_reg[i_a];
                    sval_reg[isel][0] <= '0;
                end else begin
                    stag_reg[isel][0] <= '0;
                    sval_reg[isel][0] <= rval_reg[i_a];
                end
                if (is_imm) begin
                    stag_reg[isel][1] <= '0;
                    sval_reg[isel][1] <= imm_ext[DW-1:0];
                end else if (rtag_reg[i_b] != '0) begin
                    stag_reg[isel][1] <= rtag_reg[i_b];
                    sval_reg[isel][1] <= '0;
                end else begin
                    stag_reg[isel][1] <= '0;
                    sval_reg[isel][1] <= rval_reg[i_b];
                end
                sdest_reg[isel] <= f_dst;
                rtag_reg[i_d]   <= TW'(isel) + TW'(1);
            end
        end
    end

    // Input word and per-tick result word.
    logic [31:0] ra32, rm32;
    assign ra32 = 32'(ra);
    assign rm32 = 32'(rm);

    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= in_word;
        if (cmd.wb) begin
            res_reg[0]     <= 1'b0;
            res_reg[1]     <= fin_a;
            res_reg[4:2]   <= fin_a ? 3'(ta) : 3'd0;
            res_reg[36:5]  <= fin_a ? ra32 : 32'd0;
            res_reg[37]    <= fin_m;
            res_reg[40:38] <= fin_m ? 3'(tm) : 3'd0;
            res_reg[72:41] <= fin_m ? rm32 : 32'd0;
            res_reg[73]    <= fin_m & md_dz;
        end else if (cmd.issue) begin
            res_reg[0] <= do_issue;
        end
        if (cmd.out_load) out_reg <= {6'd0, res_reg};
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ovld_reg <= 1'b1;
        end else if (out_ready) begin
            ovld_reg <= 1'b0;
        end
    end

    assign out_word        = out_reg;
    assign out_valid       = ovld_reg;
    assign stat.mul_finish = fin_m;
    assign stat.md_done    = md_done;
    assign stat.out_full   = ovld_reg && !out_ready;

endmodule

/* hdl/tomasulo_issue_dispatch_writeback_core.sv */
// Channel   Direction  Word contents
// s_axis    in         one tick, optionally carrying one instruction
// m_axis    out        issue flag and both units' writeback results
// apb       in         add, multiply and divide latency registers
//
// Each tick steps through load, execute, writeback, issue and output states, and
// waits on the bit-serial multiply/divide unit when that unit writes back.
// The output register lets the next tick enter while a result waits.
// aresetn is synchronous and active low; it restores registers and stations.
// A stalled m_tready holds the next tick in its output state until the register frees.
module tomasulo_issue_dispatch_writeback_core #(
    parameter int ADD_STATIONS = tomis_pkg::ADD_STATIONS_DEF,
    parameter int MUL_STATIONS = tomis_pkg::MUL_STATIONS_DEF,
    parameter int NUM_REGS     = tomis_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH   = tomis_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], dest_reg[5:3], src1_reg[8:6], src2_reg[11:9], immediate[27:12]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], add_done[1], add_done_tag[4:2], add_done_value[36:5],
    // mul_done[37], mul_done_tag[40:38], mul_done_value[72:41],
    // divide_by_zero[73]
    output logic [79:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tomis_pkg::cmd_t  cmd;
    tomis_pkg::stat_t stat;

    logic [5:0] add_lat_reg, mul_lat_reg, div_lat_reg;
    logic       wr_en;

    // Latency registers.
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_lat_reg <= tomis_pkg::ADD_LAT_RST;
            mul_lat_reg <= tomis_pkg::MUL_LAT_RST;
            div_lat_reg <= tomis_pkg::DIV_LAT_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                tomis_pkg::REG_ADD_LAT: add_lat_reg <= pwdata[5:0];
                tomis_pkg::REG_MUL_LAT: mul_lat_reg <= pwdata[5:0];
                tomis_pkg::REG_DIV_LAT: div_lat_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tomis_pkg::REG_ADD_LAT: prdata = {26'd0, add_lat_reg};
            tomis_pkg::REG_MUL_LAT: prdata = {26'd0, mul_lat_reg};
            tomis_pkg::REG_DIV_LAT: prdata = {26'd0, div_lat_reg};
            default:                prdata = 32'd0;
        endcase
    end

    tomis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tomis_dp #(
        .ADD_STATIONS (ADD_STATIONS),
        .MUL_STATIONS (MUL_STATIONS),
        .NUM_REGS     (NUM_REGS),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (s_tdata),
        .add_lat   (add_lat_reg),
        .mul_lat   (mul_lat_reg),
        .div_lat   (div_lat_reg),
        .out_word  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule
